// ===== rtl/t2prs_pkg.sv =====
// ============================================================================
// t2prs_pkg
// Shared types and constants for the Thumb-2 PC-relative scanner.
// ============================================================================
package t2prs_pkg;

    localparam int CFG_W    = 11;   // width of the scan byte count register
    localparam int OFFSET_W = 12;   // byte count can pass the limit by up to 3
    localparam int HALF_W   = 16;

    localparam logic [CFG_W-1:0]    SCAN_BYTES_RESET = 11'd8;
    localparam logic [OFFSET_W-1:0] STEP_NARROW      = 12'd2;
    localparam logic [OFFSET_W-1:0] STEP_WIDE        = 12'd4;
    localparam logic [OFFSET_W-1:0] STEP_NONE        = 12'd0;

    // 32-bit forms: the first halfword sits in the upper 16 bits.
    localparam logic [31:0] MASK_BRANCH32 = 32'hF800_D000;
    localparam logic [31:0] VAL_BLX       = 32'hF800_D000;
    localparam logic [31:0] VAL_BL        = 32'hF000_D000;
    localparam logic [31:0] VAL_BCOND_W   = 32'hF000_8000;
    localparam logic [31:0] VAL_B_W       = 32'hF000_9000;
    localparam logic [31:0] MASK_ADR_W    = 32'hFBFF_8000;
    localparam logic [31:0] VAL_ADR_W_SUB = 32'hF2AF_0000;
    localparam logic [31:0] VAL_ADR_W_ADD = 32'hF20F_0000;
    localparam logic [31:0] MASK_LDR_W    = 32'hFF7F_0000;
    localparam logic [31:0] VAL_LDR_W     = 32'hF85F_0000;
    localparam logic [31:0] MASK_TB       = 32'hFFFF_00F0;
    localparam logic [31:0] VAL_TBB       = 32'hE8DF_0000;
    localparam logic [31:0] VAL_TBH       = 32'hE8DF_0010;

    // 16-bit forms.
    localparam logic [15:0] MASK_BCOND    = 16'hF000;
    localparam logic [15:0] VAL_BCOND     = 16'hD000;
    localparam logic [15:0] MASK_TOP5     = 16'hF800;
    localparam logic [15:0] VAL_B         = 16'hE000;
    localparam logic [15:0] VAL_ADR       = 16'hA000;
    localparam logic [15:0] VAL_LDR_LIT   = 16'h4800;
    localparam logic [15:0] MASK_BX       = 16'hFFF8;
    localparam logic [15:0] VAL_BX_PC     = 16'h4778;
    localparam logic [15:0] MASK_HIREG    = 16'hFF78;
    localparam logic [15:0] VAL_ADD_PC    = 16'h4478;
    localparam logic [15:0] VAL_MOV_PC    = 16'h4678;
    localparam logic [15:0] MASK_CBZ      = 16'hF500;
    localparam logic [15:0] VAL_CBZ       = 16'hB100;

    // Top five bits that open a 32-bit instruction.
    localparam logic [4:0] WIDE_TOP_A = 5'b11101;
    localparam logic [4:0] WIDE_TOP_B = 5'b11110;
    localparam logic [4:0] WIDE_TOP_C = 5'b11111;

    typedef struct packed {
        logic [HALF_W-1:0] code_half;
        logic              first_of_function;
    } t_in_item;

    typedef struct packed {
        logic             pc_relative_found;
        logic [CFG_W-1:0] covered_bytes;
    } t_out_item;

    typedef struct packed {
        logic wide_first;   // halfword opens a 32-bit instruction
        logic hit16;        // halfword is a PC-relative 16-bit form
        logic hit32;        // pending half plus this half is a PC-relative 32-bit form
    } t_decode;

endpackage

// ===== rtl/thumb2_pc_relative_scanner.sv =====
// A halfword that completes a scan gives its result via the input register, then the
// result register. Throughput: one halfword per cycle while results are taken; the
// single-pass decode and count loop sets this.
// Reset: synchronous, active low; the scan is idle until a function-start halfword,
// and the scan byte count register returns to 8.
// ============================================================================
// thumb2_pc_relative_scanner
// Splits a stream of Thumb-2 halfwords into instructions and reports whether
// any instruction inside the configured byte count is PC-relative.
// ============================================================================
module thumb2_pc_relative_scanner #(
    parameter int MAX_SCAN_BYTES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Code halfword stream.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  t2prs_pkg::t_in_item         i_in_item,
    // Scan result stream.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output t2prs_pkg::t_out_item        o_out_item,
    // Scan byte count register write.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [t2prs_pkg::CFG_W-1:0] i_cfg_data
);

    // The register holds at most 2047, so a larger maximum never limits.
    localparam int CFG_MAX = (1 << t2prs_pkg::CFG_W) - 1;
    localparam int CLIP    = (MAX_SCAN_BYTES < CFG_MAX) ? MAX_SCAN_BYTES : CFG_MAX;
    localparam logic [t2prs_pkg::CFG_W-1:0] MAX_LIMIT = t2prs_pkg::CFG_W'(CLIP);

    logic [t2prs_pkg::CFG_W-1:0] r_scan_bytes;
    logic                        r_in_valid;
    t2prs_pkg::t_in_item         r_in_item;

    logic [t2prs_pkg::CFG_W-1:0] limit;
    logic                        advance;
    logic                        in_accept;

    // The register is to be written only while the block is idle; the block does
    // not enforce this, so a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_bytes <= t2prs_pkg::SCAN_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_scan_bytes <= i_cfg_data;
        end
    end

    // The effective limit is the smaller of the register and the maximum.
    assign limit = (r_scan_bytes < MAX_LIMIT) ? r_scan_bytes : MAX_LIMIT;

    // Input register: it refills in the same cycle that its word moves on,
    // so a word can enter every cycle while the result side keeps up.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Decode, counting and the result register live in the core.
    t2prs_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_item),
        .i_limit      (limit),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== rtl/t2prs_decode.sv =====
// ============================================================================
// t2prs_decode
// Instruction length test and PC-relative mask/value table compare.
// ============================================================================
module t2prs_decode (
    input  logic [t2prs_pkg::HALF_W-1:0] i_pending_half,
    input  logic [t2prs_pkg::HALF_W-1:0] i_code_half,
    output t2prs_pkg::t_decode           o_decode
);

    logic [31:0] word;
    logic [15:0] h;
    logic [4:0]  top;

    assign word = {i_pending_half, i_code_half};
    assign h    = i_code_half;
    assign top  = i_code_half[15:11];

    always_comb begin
        o_decode.wide_first = (top == t2prs_pkg::WIDE_TOP_A) ||
                              (top == t2prs_pkg::WIDE_TOP_B) ||
                              (top == t2prs_pkg::WIDE_TOP_C);

        o_decode.hit32 =
            ((word & t2prs_pkg::MASK_BRANCH32) == t2prs_pkg::VAL_BLX)       ||
            ((word & t2prs_pkg::MASK_BRANCH32) == t2prs_pkg::VAL_BL)        ||
            ((word & t2prs_pkg::MASK_BRANCH32) == t2prs_pkg::VAL_BCOND_W)   ||
            ((word & t2prs_pkg::MASK_BRANCH32) == t2prs_pkg::VAL_B_W)       ||
            ((word & t2prs_pkg::MASK_ADR_W)    == t2prs_pkg::VAL_ADR_W_SUB) ||
            ((word & t2prs_pkg::MASK_ADR_W)    == t2prs_pkg::VAL_ADR_W_ADD) ||
            ((word & t2prs_pkg::MASK_LDR_W)    == t2prs_pkg::VAL_LDR_W)     ||
            ((word & t2prs_pkg::MASK_TB)       == t2prs_pkg::VAL_TBB)       ||
            ((word & t2prs_pkg::MASK_TB)       == t2prs_pkg::VAL_TBH);

        o_decode.hit16 =
            ((h & t2prs_pkg::MASK_BCOND) == t2prs_pkg::VAL_BCOND)   ||
            ((h & t2prs_pkg::MASK_TOP5)  == t2prs_pkg::VAL_B)       ||
            ((h & t2prs_pkg::MASK_BX)    == t2prs_pkg::VAL_BX_PC)   ||
            ((h & t2prs_pkg::MASK_HIREG) == t2prs_pkg::VAL_ADD_PC)  ||
            ((h & t2prs_pkg::MASK_HIREG) == t2prs_pkg::VAL_MOV_PC)  ||
            ((h & t2prs_pkg::MASK_TOP5)  == t2prs_pkg::VAL_ADR)     ||
            ((h & t2prs_pkg::MASK_TOP5)  == t2prs_pkg::VAL_LDR_LIT) ||
            ((h & t2prs_pkg::MASK_CBZ)   == t2prs_pkg::VAL_CBZ);
    end

endmodule

// ===== rtl/t2prs_core.sv =====
// ============================================================================
// t2prs_core
// Scan state, byte counting and the result register.
// ============================================================================
module t2prs_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  t2prs_pkg::t_in_item         i_item,
    input  logic [t2prs_pkg::CFG_W-1:0] i_limit,
    output logic                        o_advance,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output t2prs_pkg::t_out_item        o_out_item
);

    logic [t2prs_pkg::HALF_W-1:0]   r_pending;
    logic                           r_awaiting;
    logic [t2prs_pkg::OFFSET_W-1:0] r_offset;
    logic                           r_found;
    logic                           r_done;
    logic                           r_out_valid;
    t2prs_pkg::t_out_item           r_out_item;

    logic [t2prs_pkg::HALF_W-1:0]   n_pending;
    logic                           n_awaiting;
    logic [t2prs_pkg::OFFSET_W-1:0] n_offset;
    logic                           n_found;
    logic                           n_done;
    t2prs_pkg::t_out_item           n_out_item;

    t2prs_pkg::t_decode             dec;
    logic                           first;
    logic                           active;
    logic                           zero_limit;
    logic                           aw;
    logic [t2prs_pkg::OFFSET_W-1:0] off_base;
    logic                           found_base;
    logic [t2prs_pkg::OFFSET_W-1:0] step;
    logic [t2prs_pkg::OFFSET_W-1:0] off_sum;
    logic                           found_sum;
    logic                           complete;
    logic                           reached;
    logic                           emit;

    t2prs_decode u_decode (
        .i_pending_half (r_pending),
        .i_code_half    (i_item.code_half),
        .o_decode       (dec)
    );

    // The held item moves on once the result register is free or being read.
    assign o_advance = i_item_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        first      = i_item.first_of_function;
        active     = first || !r_done;
        zero_limit = first && (i_limit == '0);
        aw         = first ? 1'b0 : r_awaiting;
        off_base   = first ? '0 : r_offset;
        found_base = first ? 1'b0 : r_found;

        if (aw) begin
            step      = t2prs_pkg::STEP_WIDE;
            found_sum = found_base | dec.hit32;
        end else if (dec.wide_first) begin
            step      = t2prs_pkg::STEP_NONE;
            found_sum = found_base;
        end else begin
            step      = t2prs_pkg::STEP_NARROW;
            found_sum = found_base | dec.hit16;
        end
        off_sum  = off_base + step;
        complete = aw || !dec.wide_first;
        reached  = complete && (off_sum >= {1'b0, i_limit});
        emit     = active && (zero_limit || reached);
    end

    always_comb begin
        n_pending  = r_pending;
        n_awaiting = r_awaiting;
        n_offset   = r_offset;
        n_found    = r_found;
        n_done     = r_done;
        if (o_advance && active) begin
            if (zero_limit) begin
                n_awaiting = 1'b0;
                n_offset   = '0;
                n_found    = 1'b0;
                n_done     = 1'b1;
            end else begin
                n_awaiting = !aw && dec.wide_first;
                if (!aw && dec.wide_first) begin
                    n_pending = i_item.code_half;
                end
                n_offset = off_sum;
                n_found  = found_sum;
                n_done   = reached;
            end
        end
    end

    always_comb begin
        if (zero_limit) begin
            n_out_item = '0;
        end else begin
            n_out_item.pc_relative_found = found_sum;
            n_out_item.covered_bytes     = off_sum[t2prs_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_awaiting  <= 1'b0;
            r_offset    <= '0;
            r_found     <= 1'b0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_pending  <= n_pending;
            r_awaiting <= n_awaiting;
            r_offset   <= n_offset;
            r_found    <= n_found;
            r_done     <= n_done;
            if (o_advance) begin
                r_out_valid <= emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // A finished scan never holds a half-seen 32-bit instruction.
    a_done_not_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> !r_done)
        else $error("scan finished while a first halfword is pending");

    // Instruction lengths keep the byte count even.
    a_offset_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_offset[0])
        else $error("byte count is odd");

    // Halfwords that arrive between functions leave the count alone.
    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && r_done && !i_item.first_of_function) |=> $stable(r_offset))
        else $error("idle halfword changed the byte count");

    // A result always reports a whole number of halfwords.
    a_result_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_out_item.covered_bytes[0])
        else $error("result byte count is odd");
`endif

endmodule

// ===== tb/t2prs_scan_checker.sv =====
// ----------------------------------------------------------------------------
// t2prs_scan_checker
// Watches the halfword, result and register channels of the Thumb-2
// PC-relative scanner, predicts every scan result and compares it field by
// field against what the block delivers.
// ----------------------------------------------------------------------------
module t2prs_scan_checker #(
    parameter int MAX_SCAN_BYTES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  t2prs_pkg::t_in_item         i_in_item,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  t2prs_pkg::t_out_item        i_out_item,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [t2prs_pkg::CFG_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_expect_count,
    output int                          o_halves_seen,
    output int                          o_scans_checked,
    output int                          o_pcrel_scans,
    output bit                          o_scan_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    import t2prs_pkg::*;

    // Shadow copy of the scanner state.
    logic [CFG_W-1:0] scan_limit_reg;
    logic [15:0]      held_upper;
    bit               upper_waiting;
    int               scanned_bytes;
    bit               pcrel_seen;
    bit               scan_finished;

    t_out_item        pending_scans[$];

    function automatic bit opens_wide(input logic [15:0] h);
        return h[15:11] == 5'b11101 || h[15:11] == 5'b11110 || h[15:11] == 5'b11111;
    endfunction

    function automatic bit is_pcrel_wide(input logic [31:0] w);
        return (w & 32'hF800_D000) == 32'hF800_D000     // blx
            || (w & 32'hF800_D000) == 32'hF000_D000     // bl
            || (w & 32'hF800_D000) == 32'hF000_8000     // conditional b.w
            || (w & 32'hF800_D000) == 32'hF000_9000     // b.w
            || (w & 32'hFBFF_8000) == 32'hF2AF_0000     // adr.w, subtract form
            || (w & 32'hFBFF_8000) == 32'hF20F_0000     // adr.w, add form
            || (w & 32'hFF7F_0000) == 32'hF85F_0000     // ldr.w literal
            || (w & 32'hFFFF_00F0) == 32'hE8DF_0000     // tbb
            || (w & 32'hFFFF_00F0) == 32'hE8DF_0010;    // tbh
    endfunction

    function automatic bit is_pcrel_narrow(input logic [15:0] h);
        return (h & 16'hF000) == 16'hD000               // conditional b
            || (h & 16'hF800) == 16'hE000               // b
            || (h & 16'hFFF8) == 16'h4778               // bx pc
            || (h & 16'hFF78) == 16'h4478               // add rd, pc
            || (h & 16'hFF78) == 16'h4678               // mov rd, pc
            || (h & 16'hF800) == 16'hA000               // adr
            || (h & 16'hF800) == 16'h4800               // ldr literal
            || (h & 16'hF500) == 16'hB100;              // cbz / cbnz
    endfunction

    // Moves the shadow scan forward by one halfword. Returns 1 when the
    // halfword finishes a scan, with the result in res.
    function automatic bit advance_scan(input t_in_item it, output t_out_item res);
        int lim;
        res = '0;
        lim = (int'(scan_limit_reg) < MAX_SCAN_BYTES) ? int'(scan_limit_reg) : MAX_SCAN_BYTES;
        if (it.first_of_function) begin
            held_upper    = '0;
            upper_waiting = 1'b0;
            scanned_bytes = 0;
            pcrel_seen    = 1'b0;
            scan_finished = 1'b0;
            if (lim == 0) begin
                scan_finished = 1'b1;
                return 1'b1;
            end
        end else if (scan_finished) begin
            return 1'b0;
        end

        if (upper_waiting) begin
            if (is_pcrel_wide({held_upper, it.code_half}))
                pcrel_seen = 1'b1;
            upper_waiting = 1'b0;
            scanned_bytes += 4;
        end else if (opens_wide(it.code_half)) begin
            held_upper    = it.code_half;
            upper_waiting = 1'b1;
            return 1'b0;
        end else begin
            if (is_pcrel_narrow(it.code_half))
                pcrel_seen = 1'b1;
            scanned_bytes += 2;
        end

        if (scanned_bytes >= lim) begin
            scan_finished = 1'b1;
            res.pc_relative_found = pcrel_seen;
            res.covered_bytes     = scanned_bytes[CFG_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item predicted;
        t_out_item wanted;
        if (!i_rst_n) begin
            scan_limit_reg = SCAN_BYTES_RESET;
            held_upper     = '0;
            upper_waiting  = 1'b0;
            scanned_bytes  = 0;
            pcrel_seen     = 1'b0;
            scan_finished  = 1'b1;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                scan_limit_reg = i_cfg_data;

            // Inputs first, so a result that could follow at once finds its prediction.
            if (i_in_valid && !i_in_stall) begin
                o_halves_seen++;
                if (advance_scan(i_in_item, predicted))
                    pending_scans.push_back(predicted);
            end

            if (i_out_valid && !i_out_stall) begin
                if (pending_scans.size() == 0) begin
                    $error("unexpected scan result: pc_relative_found=%0d covered_bytes=%0d",
                           i_out_item.pc_relative_found, i_out_item.covered_bytes);
                    o_fail_count++;
                end else begin
                    wanted = pending_scans.pop_front();
                    o_scans_checked++;
                    if (wanted.pc_relative_found)
                        o_pcrel_scans++;
                    if (i_out_item.pc_relative_found !== wanted.pc_relative_found) begin
                        $error("pc_relative_found: expected %0d, actual %0d",
                               wanted.pc_relative_found, i_out_item.pc_relative_found);
                        o_fail_count++;
                    end
                    if (i_out_item.covered_bytes !== wanted.covered_bytes) begin
                        $error("covered_bytes: expected %0d, actual %0d",
                               wanted.covered_bytes, i_out_item.covered_bytes);
                        o_fail_count++;
                    end
                end
            end
        end
        o_expect_count = pending_scans.size();
        o_scan_idle    = scan_finished;
    end

endmodule

// ===== tb/thumb2_pc_relative_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// thumb2_pc_relative_scanner_tb
// Feeds the scanner with function bodies of mixed 16-bit and 32-bit Thumb-2
// code, PC-relative forms among them, under a range of scan byte counts,
// with random gaps on both channels and one long hold-off on the results.
// A checker beside the block predicts and compares every scan result.
// ----------------------------------------------------------------------------
module thumb2_pc_relative_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import t2prs_pkg::*;

    localparam int SCAN_MAX = 1024;
    localparam int N_PHASES = 9;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_item;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    int fail_count;
    int expect_count;
    int halves_seen;
    int scans_checked;
    int pcrel_scans;
    bit scan_idle;

    // Shared between the word sender and the result receiver.
    bit idle_on = 1'b1;
    int rx_hold_cycles = 0;
    int n_sent = 0;
    int settings_used = 0;

    // Byte counts per phase and how many counted words each phase offers.
    // The last phase picks a small count at random.
    int phase_bytes [N_PHASES] = '{8, 2, 3, 1, 16, 0, 2047, 1024, 0};
    int phase_items [N_PHASES] = '{200, 200, 120, 100, 200, 40, 1, 1, 60};

    always #5ns i_clk = ~i_clk;

    thumb2_pc_relative_scanner #(
        .MAX_SCAN_BYTES (SCAN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    t2prs_scan_checker #(
        .MAX_SCAN_BYTES (SCAN_MAX)
    ) scan_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_item       (i_in_item),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_item      (o_out_item),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_expect_count  (expect_count),
        .o_halves_seen   (halves_seen),
        .o_scans_checked (scans_checked),
        .o_pcrel_scans   (pcrel_scans),
        .o_scan_idle     (scan_idle)
    );

    // A clean halfword comes from the shift/add/move-immediate space, which
    // holds no PC-relative form. Otherwise a PC-relative form is picked now
    // and then, with its free bits random, or any 16-bit encoding at all.
    function automatic logic [15:0] narrow_half(input bit clean);
        logic [15:0] r;
        r = 16'($urandom);
        if (clean)
            return 16'($urandom_range(0, 16'h3FFF));
        case ($urandom_range(0, 31))
            0:       return (r & ~MASK_BCOND)  | VAL_BCOND;
            1:       return (r & ~MASK_TOP5)   | VAL_B;
            2:       return (r & ~MASK_BX)     | VAL_BX_PC;
            3:       return (r & ~MASK_HIREG)  | VAL_ADD_PC;
            4:       return (r & ~MASK_HIREG)  | VAL_MOV_PC;
            5:       return (r & ~MASK_TOP5)   | VAL_ADR;
            6:       return (r & ~MASK_TOP5)   | VAL_LDR_LIT;
            7:       return (r & ~MASK_CBZ)    | VAL_CBZ;
            default: return 16'($urandom_range(0, 16'hE7FF));
        endcase
    endfunction

    // A 32-bit instruction with the first halfword in the upper bits. The
    // clean ones open with 11101 and avoid the table branch prefix, so no
    // PC-relative form can match them.
    function automatic logic [31:0] wide_word(input bit clean);
        logic [31:0] r;
        logic [15:0] upper;
        r = $urandom;
        if (clean) begin
            upper = {WIDE_TOP_A, r[26:16]};
            if (upper == VAL_TBB[31:16])
                upper = upper ^ 16'h0001;
            return {upper, r[15:0]};
        end
        case ($urandom_range(0, 19))
            0:       return (r & ~MASK_BRANCH32) | VAL_BLX;
            1:       return (r & ~MASK_BRANCH32) | VAL_BL;
            2:       return (r & ~MASK_BRANCH32) | VAL_BCOND_W;
            3:       return (r & ~MASK_BRANCH32) | VAL_B_W;
            4:       return (r & ~MASK_ADR_W)    | VAL_ADR_W_SUB;
            5:       return (r & ~MASK_ADR_W)    | VAL_ADR_W_ADD;
            6:       return (r & ~MASK_LDR_W)    | VAL_LDR_W;
            7:       return (r & ~MASK_TB)       | VAL_TBB;
            8:       return (r & ~MASK_TB)       | VAL_TBH;
            default: begin
                upper = 16'($urandom_range(16'hE800, 16'hFFFF));
                return {upper, r[15:0]};
            end
        endcase
    endfunction

    // Offers one word and returns once it has been accepted. Valid stays high
    // afterward, so back-to-back words need no gap; a random gap is inserted
    // before the word while idling is on. Words the block merely ignores are
    // sent with counted low so that they do not count toward a phase.
    task automatic send_half(input logic [15:0] h, input bit first, input bit counted);
        t_in_item it;
        it.code_half         = h;
        it.first_of_function = first;
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (counted)
            n_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // One function body. Most cover the byte count exactly or run a little
    // past it, so that the tail is ignored. A few are cut short and left to
    // the next function start, some of those in the middle of a 32-bit
    // instruction. Now and then a noise word with random bits and a random
    // start flag is slipped in.
    task automatic send_function(input int limit);
        int          target;
        int          bytes_out;
        bit          clean;
        bit          first;
        bit          cut_short;
        logic [31:0] w;
        clean     = ($urandom_range(0, 9) < 4);
        target    = limit;
        cut_short = (limit > 2 && limit <= 64 && $urandom_range(0, 9) == 0);
        if (cut_short)
            target = 2 * $urandom_range(0, (limit - 1) / 2);
        bytes_out = 0;
        first     = 1'b1;
        do begin
            if (!first && !clean && limit <= 64 && $urandom_range(0, 49) == 0) begin
                send_half(16'($urandom), $urandom_range(0, 3) == 0, 1'b1);
            end else if ($urandom_range(0, 9) < 3) begin
                w = wide_word(clean);
                send_half(w[31:16], first, 1'b1);
                send_half(w[15:0], 1'b0, 1'b1);
                bytes_out += 4;
            end else begin
                send_half(narrow_half(clean), first, 1'b1);
                bytes_out += 2;
            end
            first = 1'b0;
        end while (bytes_out < target);

        if (cut_short && $urandom_range(0, 1) == 1)
            send_half({WIDE_TOP_B, 11'($urandom)}, 1'b0, 1'b1);
        else if (!cut_short && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_half(narrow_half(clean), 1'b0, 1'b0);
    endtask

    // Brings the block to rest: any open scan is completed with plain
    // 16-bit instructions, every expected result is awaited, and a final
    // wait covers a word still in the pipeline that gives no result.
    // The idle flag is read at the falling edge, after the checker has
    // taken in the last accepted word.
    task automatic settle_block();
        drop_valid();
        while (!scan_idle) begin
            send_half(narrow_half(1'b1), 1'b0, 1'b1);
            drop_valid();
        end
        while (expect_count != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_scan_bytes(input logic [CFG_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Result receiver: a long hold-off when asked for, otherwise random
    // stalls while idling is on.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                rx_hold_cycles--;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(0, 99) < 25);
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] value;
        int               limit;
        int               start;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset byte count of 8 first.
        // A word without a function start right after reset is ignored.
        send_half(16'hFFFF, 1'b0, 1'b0);
        // Plain start, bx pc, then a blx built from two all-ones halfwords.
        send_half(16'h0000, 1'b1, 1'b1);
        send_half(16'h4778, 1'b0, 1'b1);
        send_half(16'hFFFF, 1'b0, 1'b1);
        send_half(16'hFFFF, 1'b0, 1'b1);
        // The scan is over, so this word is ignored.
        send_half(16'h1234, 1'b0, 1'b0);
        // A new start lands on a pending first half, which must be dropped.
        send_half(16'hF000, 1'b1, 1'b1);
        send_half(16'hBF00, 1'b1, 1'b1);
        send_half(16'hE8DF, 1'b0, 1'b1);
        send_half(16'h001F, 1'b0, 1'b1);
        send_half(16'h2000, 1'b0, 1'b1);
        // A literal ldr.w straddles the count, so 10 bytes are covered.
        send_half(16'hBF00, 1'b1, 1'b1);
        send_half(16'hBF00, 1'b0, 1'b1);
        send_half(16'hBF00, 1'b0, 1'b1);
        send_half(16'hF85F, 1'b0, 1'b1);
        send_half(16'h1000, 1'b0, 1'b1);
        // A zero count answers at the function start without decoding.
        write_scan_bytes('0);
        send_half(16'hD000, 1'b1, 1'b1);
        send_half(16'h4800, 1'b0, 1'b0);
        // A count of one still covers a whole instruction.
        write_scan_bytes(11'd1);
        send_half(16'h4800, 1'b1, 1'b1);
        send_half(16'hF20F, 1'b1, 1'b1);
        send_half(16'h0000, 1'b0, 1'b1);

        // Random part, one byte count per phase. The 16-byte phase runs with
        // no idling on either side; the 2-byte phase opens with a long
        // hold-off on the results while words keep coming, so the block
        // fills up and stalls its input.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1)
                value = CFG_W'($urandom_range(5, 40));
            else
                value = phase_bytes[p][CFG_W-1:0];
            limit = (int'(value) > SCAN_MAX) ? SCAN_MAX : int'(value);
            write_scan_bytes(value);
            idle_on = (value != 11'd16);
            if (value == 11'd2)
                rx_hold_cycles = 80;
            start = n_sent;
            while (n_sent - start < phase_items[p])
                send_function(limit);
            idle_on = 1'b1;
        end

        drop_valid();
        while (expect_count != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Sent %0d halfwords under %0d byte-count settings, from 0 up to 2047.",
                 halves_seen, settings_used);
        $display("Checked %0d scan results, %0d of them with PC-relative code.",
                 scans_checked, pcrel_scans);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== thumb2_pc_relative_scanner.f =====
rtl/t2prs_pkg.sv
rtl/t2prs_decode.sv
rtl/t2prs_core.sv
rtl/thumb2_pc_relative_scanner.sv
tb/t2prs_scan_checker.sv
tb/thumb2_pc_relative_scanner_tb.sv
